FILE: hdl/pbg_pkg.sv
package pbg_pkg;

  // Field widths of the beats and of the configuration registers.
  localparam int unsigned SecsW     = 6;
  localparam int unsigned MaxRunW   = 16;
  localparam int unsigned LimitW    = 20;
  localparam int unsigned DayW      = 27;
  localparam int unsigned UsedW     = 21;
  localparam int unsigned RunW      = 16;
  localparam int unsigned CfgDataW  = 27;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ClampW    = 5;
  localparam int unsigned MsW       = 15;

  localparam logic [MaxRunW-1:0] MaxRunReset   = 16'd30000;
  localparam logic [LimitW-1:0]  LimitReset    = 20'd300000;
  localparam logic [DayW-1:0]    DayLenReset   = 27'd86400000;
  localparam logic [ClampW-1:0]  SecondsCap    = 5'd30;
  localparam logic [MsW-1:0]     MsPerSecond   = 15'd1000;
  localparam logic [UsedW-1:0]   UsedMax       = 21'h1FFFFF;
  localparam logic [RunW-1:0]    RunMax        = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxRun     = 2'd0,
    CfgDailyLimit = 2'd1,
    CfgDayLength  = 2'd2
  } cfg_idx_e;

  // Item kinds carried in the action field.
  typedef enum logic {
    ActTick    = 1'b0,
    ActRequest = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic [SecsW-1:0] request_seconds;
    logic             water_low;
  } in_t;

  typedef struct packed {
    logic             pump_on;
    logic             request_ok;
    logic [UsedW-1:0] used_today_ms;
  } out_t;

  typedef struct packed {
    logic [MaxRunW-1:0] max_run_ms;
    logic [LimitW-1:0]  daily_limit_ms;
    logic [DayW-1:0]    day_length_ms;
  } cfg_t;

endpackage

FILE: hdl/pbg_cfg_regs.sv
module pbg_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pbg_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output pbg_pkg::cfg_t                  cfg_o
);

  pbg_pkg::cfg_t cfg_q, cfg_d;

  // Writes to an unused index are dropped; data is cut to the register width.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbg_pkg::CfgMaxRun:     cfg_d.max_run_ms     = cfg_wdata_i[pbg_pkg::MaxRunW-1:0];
        pbg_pkg::CfgDailyLimit: cfg_d.daily_limit_ms = cfg_wdata_i[pbg_pkg::LimitW-1:0];
        pbg_pkg::CfgDayLength:  cfg_d.day_length_ms  = cfg_wdata_i[pbg_pkg::DayW-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_run_ms     <= pbg_pkg::MaxRunReset;
      cfg_q.daily_limit_ms <= pbg_pkg::LimitReset;
      cfg_q.day_length_ms  <= pbg_pkg::DayLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/pbg_core.sv
module pbg_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  pbg_pkg::in_t   item_i,
  input  pbg_pkg::cfg_t  cfg_i,
  output pbg_pkg::out_t  res_o
);

  logic                        running_q, running_d;
  logic [pbg_pkg::RunW-1:0]    run_elapsed_q, run_elapsed_d;
  logic [pbg_pkg::RunW-1:0]    run_target_q, run_target_d;
  logic [pbg_pkg::UsedW-1:0]   used_q, used_d;
  logic [pbg_pkg::DayW-1:0]    day_q, day_d;

  logic [pbg_pkg::ClampW-1:0]  secs_c;
  logic [pbg_pkg::MsW-1:0]     req_ms;
  logic [pbg_pkg::RunW-1:0]    elapsed_t;
  logic [pbg_pkg::RunW-1:0]    add_ms;
  logic [pbg_pkg::UsedW:0]     sum_ms;
  logic [pbg_pkg::UsedW-1:0]   used_halt;
  logic                        ok;
  logic                        do_halt;

  always_comb begin
    secs_c = (item_i.request_seconds > pbg_pkg::SecondsCap) ?
             pbg_pkg::SecondsCap : item_i.request_seconds[pbg_pkg::ClampW-1:0];
    req_ms = pbg_pkg::MsW'(pbg_pkg::MsW'(secs_c) * pbg_pkg::MsPerSecond);

    // The run counter advances only on ticks while the pump runs.
    elapsed_t = run_elapsed_q;
    if (item_i.action == pbg_pkg::ActTick && running_q && run_elapsed_q != pbg_pkg::RunMax) begin
      elapsed_t = run_elapsed_q + 1'b1;
    end

    add_ms    = (elapsed_t < cfg_i.max_run_ms) ? elapsed_t : cfg_i.max_run_ms;
    sum_ms    = {1'b0, used_q} + (pbg_pkg::UsedW + 1)'(add_ms);
    used_halt = sum_ms[pbg_pkg::UsedW] ? pbg_pkg::UsedMax : sum_ms[pbg_pkg::UsedW-1:0];
  end

  always_comb begin
    running_d     = running_q;
    run_elapsed_d = run_elapsed_q;
    run_target_d  = run_target_q;
    used_d        = used_q;
    day_d         = day_q;
    ok            = 1'b0;
    do_halt       = 1'b0;

    if (item_i.action == pbg_pkg::ActRequest) begin
      if (secs_c == '0) begin
        do_halt = 1'b1;
        ok      = 1'b1;
      end else if (!item_i.water_low && !running_q &&
                   used_q < {1'b0, cfg_i.daily_limit_ms}) begin
        run_target_d  = ({1'b0, req_ms} < cfg_i.max_run_ms) ? {1'b0, req_ms} : cfg_i.max_run_ms;
        run_elapsed_d = '0;
        running_d     = 1'b1;
        ok            = 1'b1;
      end
    end else begin
      run_elapsed_d = elapsed_t;
      day_d         = day_q + 1'b1;
      do_halt       = running_q && (item_i.water_low || elapsed_t >= run_target_q);
    end

    if (do_halt) begin
      if (running_q) begin
        used_d = used_halt;
      end
      running_d = 1'b0;
    end

    // Day end comes after any stop on the same tick, so it wins.
    if (item_i.action == pbg_pkg::ActTick && day_d >= cfg_i.day_length_ms) begin
      used_d = '0;
      day_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= 1'b0;
      run_elapsed_q <= '0;
      run_target_q  <= '0;
      used_q        <= '0;
      day_q         <= '0;
    end else if (fire_i) begin
      running_q     <= running_d;
      run_elapsed_q <= run_elapsed_d;
      run_target_q  <= run_target_d;
      used_q        <= used_d;
      day_q         <= day_d;
    end
  end

  assign res_o.pump_on       = running_d;
  assign res_o.request_ok    = ok;
  assign res_o.used_today_ms = used_d;

  // A running pump never gets past its target without being stopped.
  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> run_elapsed_q <= run_target_q)
    else $error("run counter passed its target while running");

  // Low water on a tick always leaves the pump off.
  a_low_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.action == pbg_pkg::ActTick && item_i.water_low |=> !running_q)
    else $error("pump still running after a low-water tick");

  // A start request while running is refused.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.action == pbg_pkg::ActRequest && item_i.request_seconds != '0 && running_q
    |-> !res_o.request_ok)
    else $error("start accepted while pump was running");

endmodule

FILE: hdl/pump_run_and_daily_budget_guard.sv
// Pump run guard with a daily time budget.
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one beat per item: either a
// one-millisecond tick or a run request, each with the current low-water level. The output
// channel (out_valid_o, out_ready_i, out_data_o) returns exactly one beat per input beat, in
// order, giving the pump drive level, whether a request was taken, and the usage of the day.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i): index 0 is the
// longest run, 1 the daily budget, 2 the day length. Write it only while no beat is in flight.
// A beat accepted sits in the input register; when it advances, the state update is done
// and the result register captures its output beat. Throughput is one beat per cycle while
// the receiver takes beats; the pump state and counters are updated in the same cycle the
// result is captured, so the next beat sees them at once.
// When the receiver stalls, the result stays in the output register and one more beat can
// wait in the input register; after that in_ready_o drops until the receiver takes a beat.
// Reset clears the pump state, the run and day counters and the usage, and restores the
// configuration defaults (30000 ms run, 300000 ms budget, 86400000 ms day).
module pump_run_and_daily_budget_guard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pbg_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pbg_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pbg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pbg_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  pbg_pkg::cfg_t cfg;
  pbg_pkg::out_t res;

  logic          in_valid_q, in_valid_d;
  pbg_pkg::in_t  in_item_q;
  logic          out_valid_q, out_valid_d;
  pbg_pkg::out_t out_data_q;
  logic          advance;
  logic          in_fire;

  // The held beat moves on when the output register is free or is being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : ((out_valid_q && out_ready_i) ? 1'b0 : out_valid_q);
  end

  pbg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pbg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A stalled receiver keeps the waiting input beat in place.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |=> in_valid_q && $stable(in_item_q))
    else $error("input stage lost a beat during a stall");

  // Each advance produces an output beat in the next cycle.
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced beat did not reach the output register");

  // With both registers full and the receiver stalled, no new beat is taken.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input beat taken while both registers were full");

endmodule
